>>> sv/one_wire_bus_master_assert.svh
// Assertion macros for the single-wire bus master.
// Used by one_wire_bus_master.sv; the macros expect signals named clk and rst.
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OWB_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("one_wire_bus_master: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define OWB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("one_wire_bus_master: next-cycle check failed");

`endif

>>> sv/owb_pkg.sv
// Package for the single-wire bus master: transaction types, command codes,
// configuration register indexes and reset values. No dependencies.
package owb_pkg;

  // Commands carried with each tick.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam int unsigned CfgIndexWidth = 3;
  localparam logic [CfgIndexWidth-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_PRES_TIMEOUT  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_RESET_REC     = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_SLOT_LOW      = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_SLOT_DATA     = 3'd4;
  localparam logic [CfgIndexWidth-1:0] CFG_WRITE_REC     = 3'd5;

  // Register reset values.
  localparam logic [7:0] RESET_LOW_INIT     = 8'd70;
  localparam logic [7:0] PRES_TIMEOUT_INIT  = 8'd100;
  localparam logic [7:0] RESET_REC_INIT     = 8'd50;
  localparam logic [3:0] SLOT_LOW_INIT      = 4'd1;
  localparam logic [3:0] SLOT_DATA_INIT     = 4'd3;
  localparam logic [3:0] WRITE_REC_INIT     = 4'd1;

  // Last bit position of a byte.
  localparam logic [2:0] LAST_BIT = 3'd7;

  // One input transaction: one timebase tick.
  typedef struct packed {
    op_t        op;
    logic [7:0] write_data;
    logic       line_in;
  } in_item_t;

  // One result transaction per tick.
  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       presence_error;
  } out_item_t;

endpackage

>>> sv/one_wire_bus_master.sv
// Single-wire bus master: reset with presence detect, byte write, byte read.
// Depends on owb_pkg and one_wire_bus_master_assert.svh.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+----------------------------------
//  in      | in_valid / in_stall  | in_data  (owb_pkg::in_item_t)
//  out     | out_valid / out_stall| out_data (owb_pkg::out_item_t)
//  cfg     | cfg_valid / cfg_ready| cfg_index (3 bit), cfg_data (8 bit)
//
// Each tick transaction is taken while in_stall is low; the bus state and the
// result are computed in the same cycle and land in the output register or skid.
// A two-entry output buffer (output register plus skid) lets a new tick be
// taken while the previous result waits; in_stall rises only when both hold.
// Reset (rst, synchronous) returns the sequencer to idle, clears the read
// byte and the error flag, and loads the timing registers with their defaults.
// cfg_ready is always high.
module one_wire_bus_master
  import owb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [7:0]               cfg_data
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WLOW,
    PH_RST_WHIGH,
    PH_RST_REC,
    PH_WR_LOW,
    PH_WR_DATA,
    PH_WR_REC,
    PH_RD_LOW,
    PH_RD_REL
  } phase_t;

  // Timing registers.
  logic [7:0] reset_low_ticks;
  logic [7:0] presence_timeout_ticks;
  logic [7:0] reset_recovery_ticks;
  logic [3:0] slot_low_ticks;
  logic [3:0] slot_data_ticks;
  logic [3:0] write_recovery_ticks;

  // Sequencer state.
  phase_t     phase, phase_next;
  logic [7:0] tick_count, tick_count_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_data, shift_data_next;
  logic       error_flag, error_flag_next;
  logic [7:0] last_read, last_read_next;

  // Output buffer.
  out_item_t  result;
  out_item_t  skid_data;
  logic       skid_valid;
  logic       in_accept;
  logic       out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_ticks        <= RESET_LOW_INIT;
      presence_timeout_ticks <= PRES_TIMEOUT_INIT;
      reset_recovery_ticks   <= RESET_REC_INIT;
      slot_low_ticks         <= SLOT_LOW_INIT;
      slot_data_ticks        <= SLOT_DATA_INIT;
      write_recovery_ticks   <= WRITE_REC_INIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RESET_LOW:    reset_low_ticks        <= cfg_data;
        CFG_PRES_TIMEOUT: presence_timeout_ticks <= cfg_data;
        CFG_RESET_REC:    reset_recovery_ticks   <= cfg_data;
        CFG_SLOT_LOW:     slot_low_ticks         <= cfg_data[3:0];
        CFG_SLOT_DATA:    slot_data_ticks        <= cfg_data[3:0];
        CFG_WRITE_REC:    write_recovery_ticks   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // One tick of the sequencer: command start, then the active phase.
  always_comb begin : step_logic
    logic [7:0] tc_inc;
    logic       den;
    logic       dlev;
    logic       done;
    logic       end_bit;

    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_data_next = shift_data;
    error_flag_next = error_flag;
    last_read_next  = last_read;
    den             = 1'b0;
    dlev            = 1'b0;
    done            = 1'b0;
    end_bit         = 1'b0;

    // A command taken while idle also serves as the first tick of its phase.
    if (phase == PH_IDLE) begin
      case (in_data.op)
        OP_RESET: begin
          error_flag_next = 1'b0;
          phase_next      = PH_RST_LOW;
          tick_count_next = '0;
        end
        OP_WRITE: begin
          shift_data_next = in_data.write_data;
          bit_index_next  = '0;
          phase_next      = PH_WR_LOW;
          tick_count_next = '0;
        end
        OP_READ: begin
          shift_data_next = '0;
          bit_index_next  = '0;
          phase_next      = PH_RD_LOW;
          tick_count_next = '0;
        end
        default: ;
      endcase
    end

    tc_inc = tick_count_next + 8'd1;

    case (phase_next)
      PH_RST_LOW: begin
        den = 1'b1;
        tick_count_next = tc_inc;
        if (tc_inc >= reset_low_ticks) begin
          phase_next      = PH_RST_WLOW;
          tick_count_next = '0;
        end
      end
      PH_RST_WLOW: begin
        if (!in_data.line_in) begin
          phase_next      = PH_RST_WHIGH;
          tick_count_next = '0;
        end else begin
          tick_count_next = tc_inc;
          if (tc_inc >= presence_timeout_ticks) begin
            error_flag_next = 1'b1;
            done            = 1'b1;
            phase_next      = PH_IDLE;
            tick_count_next = '0;
          end
        end
      end
      PH_RST_WHIGH: begin
        if (in_data.line_in) begin
          tick_count_next = '0;
          if (reset_recovery_ticks == 8'd0) begin
            done       = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_RST_REC;
          end
        end else begin
          tick_count_next = tc_inc;
          if (tc_inc >= presence_timeout_ticks) begin
            error_flag_next = 1'b1;
            done            = 1'b1;
            phase_next      = PH_IDLE;
            tick_count_next = '0;
          end
        end
      end
      PH_RST_REC: begin
        tick_count_next = tc_inc;
        if (tc_inc >= reset_recovery_ticks) begin
          done            = 1'b1;
          phase_next      = PH_IDLE;
          tick_count_next = '0;
        end
      end
      PH_WR_LOW: begin
        den = 1'b1;
        tick_count_next = tc_inc;
        if (tc_inc >= {4'd0, slot_low_ticks}) begin
          phase_next      = PH_WR_DATA;
          tick_count_next = '0;
        end
      end
      PH_WR_DATA: begin
        den  = 1'b1;
        dlev = shift_data_next[0];
        tick_count_next = tc_inc;
        if (tc_inc >= {4'd0, slot_data_ticks}) begin
          if (write_recovery_ticks == 4'd0) begin
            end_bit = 1'b1;
          end else begin
            phase_next      = PH_WR_REC;
            tick_count_next = '0;
          end
        end
      end
      PH_WR_REC: begin
        den  = 1'b1;
        dlev = 1'b1;
        tick_count_next = tc_inc;
        if (tc_inc >= {4'd0, write_recovery_ticks}) begin
          end_bit = 1'b1;
        end
      end
      PH_RD_LOW: begin
        den = 1'b1;
        tick_count_next = tc_inc;
        if (tc_inc >= {4'd0, slot_low_ticks}) begin
          phase_next      = PH_RD_REL;
          tick_count_next = '0;
        end
      end
      PH_RD_REL: begin
        // Sample on the first released tick of the slot.
        if (tick_count_next == 8'd0) begin
          shift_data_next = {in_data.line_in, shift_data_next[7:1]};
        end
        tick_count_next = tc_inc;
        if (tc_inc >= {4'd0, slot_data_ticks}) begin
          tick_count_next = '0;
          if (bit_index_next >= LAST_BIT) begin
            last_read_next = shift_data_next;
            done           = 1'b1;
            bit_index_next = '0;
            phase_next     = PH_IDLE;
          end else begin
            bit_index_next = bit_index_next + 3'd1;
            phase_next     = PH_RD_LOW;
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase

    // End of a written bit: next bit or finish the byte.
    if (end_bit) begin
      shift_data_next = {1'b0, shift_data_next[7:1]};
      tick_count_next = '0;
      if (bit_index_next >= LAST_BIT) begin
        done           = 1'b1;
        bit_index_next = '0;
        phase_next     = PH_IDLE;
      end else begin
        bit_index_next = bit_index_next + 3'd1;
        phase_next     = PH_WR_LOW;
      end
    end

    result.drive_enable   = den;
    result.drive_level    = den && dlev;
    result.busy_res       = (phase_next != PH_IDLE);
    result.done_res       = done;
    result.read_data      = last_read_next;
    result.presence_error = error_flag_next;
  end

  // Sequencer state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      bit_index  <= '0;
      shift_data <= '0;
      error_flag <= 1'b0;
      last_read  <= '0;
    end else if (in_accept) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift_data <= shift_data_next;
      error_flag <= error_flag_next;
      last_read  <= last_read_next;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (in_accept) begin
        out_data  <= result;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_accept) begin
      skid_data  <= result;
      skid_valid <= 1'b1;
    end
  end

  `include "one_wire_bus_master_assert.svh"

  // The skid entry is only filled behind a held result.
  `OWB_ASSERT_IMPLY(a_skid_behind_out, skid_valid, out_valid)
  // Every accepted tick leaves a result waiting.
  `OWB_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid)
  // A completing operation never reports busy on the same result.
  `OWB_ASSERT_IMPLY(a_done_not_busy, out_valid && out_data.done_res, !out_data.busy_res)
  // A released line carries no drive level.
  `OWB_ASSERT_IMPLY(a_release_level_low, out_valid && !out_data.drive_enable,
                    !out_data.drive_level)

endmodule
